/* rtl/core/srw_pkg.sv */
`timescale 1ns / 1ps
package srw_pkg;

  // default window depth and the shortest packet that is looked at
  localparam int unsigned WindowSlots = 64;
  localparam int unsigned MinLen      = 7;
  localparam int unsigned SeqW        = 16;

  // packet type codes
  localparam logic [7:0] PktTypeData = 8'd0;

  // one received packet descriptor
  typedef struct packed {
    logic [15:0] sender_id;
    logic [15:0] seq_num;
    logic [7:0]  pkt_type;
    logic [10:0] pkt_len;
    logic [15:0] buf_handle;
  } srw_in_t;

  // one released handle
  typedef struct packed {
    logic [15:0] out_handle;
    logic [15:0] out_seq;
    logic        jumped;
    logic        last;
  } srw_out_t;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StFlush,
    StInsert,
    StRun
  } srw_state_e;

  // slot store commands, all at port a
  typedef struct packed {
    logic set;
    logic clr;
    logic rd;
  } srw_store_ctrl_t;

  // release in flight, aligned with the store read data
  typedef struct packed {
    logic        valid;
    logic [15:0] seq;
    logic        jumped;
    logic        last;
  } srw_emit_t;

endpackage

/* rtl/core/sequence_reorder_window_core.sv */
`timescale 1ns / 1ps
// Reorder window for received packet descriptors: data packets are parked in
// WINDOW_SLOTS slots and their handles leave in sequence order, one item per
// cycle within a run, on result_valid_o, which must be taken as it comes (no
// back-pressure). An item is taken when start is high and busy is low. A
// dropped item, or one behind the expected sequence, ends after the check
// state; a kept one passes insert and run, which releases its in-order run,
// and a jump past the window first adds a flush scan of all WINDOW_SLOTS
// slots, one slot per cycle, due to the single port of the slot store and
// the one shared 16-bit adder walking the sequence. Results appear in the
// cycle after the slot read, so the last item of a run may show while busy is low.
module sequence_reorder_window_core #(
  parameter int unsigned WINDOW_SLOTS = srw_pkg::WindowSlots
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  srw_pkg::srw_in_t item_i,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  output logic             result_valid_o,
  output srw_pkg::srw_out_t result_o
);
  import srw_pkg::*;

  localparam int unsigned IdxW = $clog2(WINDOW_SLOTS);

  logic [15:0]     own_node_id_q;
  logic            accept;
  logic [IdxW-1:0] addr_a, addr_b;
  srw_store_ctrl_t ctrl;
  logic [15:0]     wr_data;
  logic            full_a, full_b;
  logic [15:0]     rd_data;
  srw_emit_t       emit;

  // own node id register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_node_id_q <= '0;
    end else if (cfg_we_i) begin
      own_node_id_q <= cfg_wdata_i;
    end
  end

  assign accept = start && !busy;

  srw_sequencer #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .IdxW         (IdxW)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (item_i),
    .own_id_i  (own_node_id_q),
    .full_a_i  (full_a),
    .full_b_i  (full_b),
    .addr_a_o  (addr_a),
    .addr_b_o  (addr_b),
    .ctrl_o    (ctrl),
    .wr_data_o (wr_data),
    .emit_o    (emit),
    .busy_o    (busy)
  );

  srw_slot_store #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .IdxW         (IdxW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .addr_a_i  (addr_a),
    .addr_b_i  (addr_b),
    .ctrl_i    (ctrl),
    .wr_data_i (wr_data),
    .full_a_o  (full_a),
    .full_b_o  (full_b),
    .rd_data_o (rd_data)
  );

  // result item from the read data and the aligned release info
  assign result_valid_o      = emit.valid;
  assign result_o.out_handle = rd_data;
  assign result_o.out_seq    = emit.seq;
  assign result_o.jumped     = emit.jumped;
  assign result_o.last       = emit.last;

endmodule

/* rtl/core/srw_slot_store.sv */
`timescale 1ns / 1ps
module srw_slot_store #(
  parameter int unsigned WINDOW_SLOTS = srw_pkg::WindowSlots,
  parameter int unsigned IdxW         = $clog2(WINDOW_SLOTS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [IdxW-1:0]         addr_a_i,
  input  logic [IdxW-1:0]         addr_b_i,
  input  srw_pkg::srw_store_ctrl_t ctrl_i,
  input  logic [15:0]             wr_data_i,
  output logic                    full_a_o,
  output logic                    full_b_o,
  output logic [15:0]             rd_data_o
);
  import srw_pkg::*;

  logic [WINDOW_SLOTS-1:0] full_q;
  logic [15:0]             handle_mem [WINDOW_SLOTS];
  logic [15:0]             rd_data_q;

  // occupancy flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
    end else begin
      if (ctrl_i.set) begin
        full_q[addr_a_i] <= 1'b1;
      end else if (ctrl_i.clr) begin
        full_q[addr_a_i] <= 1'b0;
      end
    end
  end

  // handle memory, one port, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.set) begin
      handle_mem[addr_a_i] <= wr_data_i;
    end
    if (ctrl_i.rd) begin
      rd_data_q <= handle_mem[addr_a_i];
    end
  end

  assign full_a_o  = full_q[addr_a_i];
  assign full_b_o  = full_q[addr_b_i];
  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/srw_sequencer.sv */
`timescale 1ns / 1ps
module srw_sequencer #(
  parameter int unsigned WINDOW_SLOTS = srw_pkg::WindowSlots,
  parameter int unsigned IdxW         = $clog2(WINDOW_SLOTS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  srw_pkg::srw_in_t         item_i,
  input  logic [15:0]              own_id_i,
  input  logic                     full_a_i,
  input  logic                     full_b_i,
  output logic [IdxW-1:0]          addr_a_o,
  output logic [IdxW-1:0]          addr_b_o,
  output srw_pkg::srw_store_ctrl_t ctrl_o,
  output logic [15:0]              wr_data_o,
  output srw_pkg::srw_emit_t       emit_o,
  output logic                     busy_o
);
  import srw_pkg::*;

  localparam logic [IdxW-1:0] SlotMask = IdxW'(WINDOW_SLOTS - 1);
  localparam logic [IdxW-1:0] LastScan = IdxW'(WINDOW_SLOTS - 1);

  srw_state_e      state_q, state_d;
  srw_in_t         item_q;
  logic            synced_q, synced_d;
  logic [15:0]     exp_q, exp_d;
  logic [15:0]     scan_q, scan_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            jmp_q, jmp_d;
  srw_emit_t       emit_q, emit_d;

  logic [15:0]     eff_exp;
  logic [15:0]     op_a, op_b;
  logic            cin;
  logic [15:0]     sum;
  logic            drop;
  logic            run_last;

  // held copy of the accepted item
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
  end

  // expected sequence as seen by the first data item
  assign eff_exp = synced_q ? exp_q : item_q.seq_num;

  assign drop = (item_q.pkt_len < 11'(MinLen)) || (item_q.sender_id == own_id_i) ||
                (item_q.pkt_type != PktTypeData);

  // shared 16-bit adder: distance in check, next sequence elsewhere
  always_comb begin
    op_a = exp_q;
    op_b = '0;
    cin  = 1'b1;
    case (state_q)
      StCheck: begin
        op_a = item_q.seq_num;
        op_b = ~eff_exp;
      end
      StFlush: begin
        op_a = scan_q;
      end
      default: begin
        op_a = exp_q;
      end
    endcase
  end

  assign sum = op_a + op_b + 16'(cin);

  // slot addresses
  always_comb begin
    case (state_q)
      StFlush: addr_a_o = scan_q[IdxW-1:0] & SlotMask;
      StRun:   addr_a_o = exp_q[IdxW-1:0] & SlotMask;
      default: addr_a_o = item_q.seq_num[IdxW-1:0] & SlotMask;
    endcase
  end

  assign addr_b_o  = sum[IdxW-1:0] & SlotMask;
  assign wr_data_o = item_q.buf_handle;

  // run ends unless the next slot in the run is full and is not the one being emptied
  assign run_last = !(full_b_i && (addr_b_o != addr_a_o));

  // next state and outputs
  always_comb begin
    state_d  = state_q;
    synced_d = synced_q;
    exp_d    = exp_q;
    scan_d   = scan_q;
    cnt_d    = cnt_q;
    jmp_d    = jmp_q;
    emit_d   = '0;
    ctrl_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept_i) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (drop) begin
          state_d = StIdle;
        end else begin
          synced_d = 1'b1;
          exp_d    = eff_exp;
          jmp_d    = 1'b0;
          scan_d   = eff_exp;
          cnt_d    = '0;
          if (sum[15]) begin
            state_d = StIdle;
          end else if (sum >= 16'(WINDOW_SLOTS)) begin
            state_d = StFlush;
          end else begin
            state_d = StInsert;
          end
        end
      end
      StFlush: begin
        if (full_a_i) begin
          ctrl_o.rd     = 1'b1;
          ctrl_o.clr    = 1'b1;
          emit_d.valid  = 1'b1;
          emit_d.seq    = scan_q;
        end
        scan_d = sum;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == LastScan) begin
          exp_d   = item_q.seq_num;
          jmp_d   = 1'b1;
          state_d = StInsert;
        end
      end
      StInsert: begin
        if (!full_a_i) begin
          ctrl_o.set = 1'b1;
        end
        state_d = StRun;
      end
      StRun: begin
        if (full_a_i) begin
          ctrl_o.rd     = 1'b1;
          ctrl_o.clr    = 1'b1;
          emit_d.valid  = 1'b1;
          emit_d.seq    = exp_q;
          emit_d.jumped = jmp_q;
          emit_d.last   = run_last;
          exp_d         = sum;
          if (run_last) begin
            state_d = StIdle;
          end
        end else begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      synced_q <= 1'b0;
      exp_q    <= '0;
      scan_q   <= '0;
      cnt_q    <= '0;
      jmp_q    <= 1'b0;
      emit_q   <= '0;
    end else begin
      state_q  <= state_d;
      synced_q <= synced_d;
      exp_q    <= exp_d;
      scan_q   <= scan_d;
      cnt_q    <= cnt_d;
      jmp_q    <= jmp_d;
      emit_q   <= emit_d;
    end
  end

  assign emit_o = emit_q;
  assign busy_o = (state_q != StIdle);

endmodule

/* rtl/core/srw_checker.sv */
`timescale 1ns / 1ps
module srw_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input srw_pkg::srw_out_t result_o
);
  import srw_pkg::*;

  // the block is always busy in the cycle after an item is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item taken but block not busy");

  // only the closing item of a run may show while the block is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !busy) |-> result_o.last)
    else $error("non-final result while idle");

  // a final result is never followed directly by another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |=> !result_valid_o)
    else $error("result straight after a final result");

  // releases after a jump come out in consecutive sequence order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.jumped && $past(result_valid_o) &&
     $past(result_o.jumped) && !$past(result_o.last))
    |-> (result_o.out_seq == 16'($past(result_o.out_seq) + 16'd1)))
    else $error("post-jump releases out of order");

endmodule

bind sequence_reorder_window_core srw_checker u_srw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
